FILE: rtl/core/stx_etx_keypad_reply_parser_macros.svh
// Assertion macros for the STX/ETX keypad reply parser.
`ifndef STX_ETX_KEYPAD_REPLY_PARSER_MACROS_SVH
`define STX_ETX_KEYPAD_REPLY_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off during reset.
`define SKPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk_i, off during reset.
`define SKPR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SKPR_ASSERT_IMP(lbl, ante, cons)
`define SKPR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/skpr_pkg.sv
// Shared types and constants of the STX/ETX keypad reply parser.
package skpr_pkg;

  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam int unsigned MIN_DATA = 4;

  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  localparam logic KIND_TAG  = 1'b0;
  localparam logic KIND_CODE = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic take_data;   // store the accepted byte as frame data
    logic clear_frame; // drop all frame state
    logic idx_clr;     // restart the emit index
    logic idx_inc;     // advance the emit index
    logic load;        // load one result beat into the output register
    logic sel_code;    // emit from the code buffer, else from the tag window
    logic last_frame;  // loaded beat closes the frame
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_stx;
    logic is_etx;
    logic is_timeout;
    logic long_enough; // more than MIN_DATA data bytes
    logic tag_ok;      // full tag window
    logic code_ok;     // code length within range
    logic idx_last;    // emit index on the last byte of the message
    logic out_free;    // output register can take a beat
  } stat_t;

endpackage

FILE: rtl/core/stx_etx_keypad_reply_parser.sv
// Top level of the STX/ETX keypad reply parser.
//
// Input stream: one beat per serial event. tuser = action (0 byte, 1 receive
// timeout), tdata = received byte. Bytes before STX are skipped; after STX
// every byte other than STX/ETX is frame data. ETX or a timeout closes the
// frame; the check byte after ETX is swallowed.
// Output stream: one beat per payload byte. The tag message (last TAG_BYTES
// bytes of the first field) comes first, then the code message (second
// field, 1 to CODE_MAX bytes). tlast marks the final beat of the frame.
// Timing: the closing beat starts a burst; the emit sequencer then loads the
// results into the output register, one beat per cycle while the sink is
// ready, TAG_BYTES + CODE_MAX beats at most. During the burst s_axis_tready_o
// is low; it rises when the last beat is loaded into the output register, so
// the next event is taken while that beat waits. A stalled sink holds the
// burst, the emit sequencer waiting on the output register. Reset clears the
// phase, counters and output valid; the byte buffers are filled only by frame
// data and need no clearing.
module stx_etx_keypad_reply_parser #(
  parameter int unsigned BUFFER_BYTES = 64,
  parameter int unsigned TAG_BYTES    = 8,
  parameter int unsigned CODE_MAX     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  input  logic        s_axis_tuser_i,  // [0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [7:0] payload_byte, [8] last_of_message, zero pad
  output logic [1:0]  m_axis_tuser_o,  // [0] message_kind, [1] overflowed
  output logic        m_axis_tlast_o   // last_of_frame
);
  import skpr_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic       kind;
  logic [7:0] pay;
  logic       last_msg;
  logic       ovf;

  skpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  skpr_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .TAG_BYTES    (TAG_BYTES),
    .CODE_MAX     (CODE_MAX)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .action_i          (s_axis_tuser_i),
    .rx_byte_i         (s_axis_tdata_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_ready_i       (m_axis_tready_i),
    .out_valid_o       (m_axis_tvalid_o),
    .message_kind_o    (kind),
    .payload_byte_o    (pay),
    .last_of_message_o (last_msg),
    .last_of_frame_o   (m_axis_tlast_o),
    .overflowed_o      (ovf)
  );

  assign m_axis_tdata_o = {7'b0, last_msg, pay};
  assign m_axis_tuser_o = {ovf, kind};

`include "stx_etx_keypad_reply_parser_macros.svh"

  // Frame end always closes a message too.
  `SKPR_ASSERT_IMP(a_frame_end_ends_msg, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tdata_o[8])
  // Within a burst the next beat follows the taken one without a gap.
  `SKPR_ASSERT_NXT(a_burst_no_gap, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, m_axis_tvalid_o)
  // Overflow status is one value for all beats of a frame.
  `SKPR_ASSERT_NXT(a_ovf_per_frame, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, $stable(m_axis_tuser_o[1]))

endmodule

FILE: rtl/core/skpr_ctrl.sv
// Frame phase and result sequencing controller.
module skpr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  skpr_pkg::stat_t stat_i,
  output skpr_pkg::cmd_t  cmd_o
);
  import skpr_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_DATA, PH_CHECK} phase_e;
  typedef enum logic [1:0] {S_RUN, S_TAG, S_CODE} state_e;

  phase_e phase_q, phase_d;
  state_e state_q, state_d;
  logic   in_fire;
  logic   finish;

  assign in_ready_o = (state_q == S_RUN);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o          = '0;
    cmd_o.sel_code = (state_q == S_CODE);
    phase_d        = phase_q;
    state_d        = state_q;
    finish         = 1'b0;

    if (in_fire) begin
      if (phase_q == PH_CHECK) begin
        phase_d = PH_IDLE;          // check byte swallowed
      end else if (stat_i.is_timeout) begin
        phase_d = PH_IDLE;
        finish  = 1'b1;
      end else if (stat_i.is_stx) begin
        phase_d = PH_DATA;
      end else if (stat_i.is_etx) begin
        phase_d = PH_CHECK;
        finish  = 1'b1;
      end else if (phase_q == PH_DATA) begin
        cmd_o.take_data = 1'b1;
      end
    end

    if (finish) begin
      if (stat_i.long_enough && stat_i.tag_ok) begin
        state_d       = S_TAG;
        cmd_o.idx_clr = 1'b1;
      end else if (stat_i.long_enough && stat_i.code_ok) begin
        state_d       = S_CODE;
        cmd_o.idx_clr = 1'b1;
      end else begin
        cmd_o.clear_frame = 1'b1;
      end
    end

    case (state_q)
      S_TAG: begin
        if (stat_i.out_free) begin
          cmd_o.load       = 1'b1;
          cmd_o.last_frame = stat_i.idx_last && !stat_i.code_ok;
          if (stat_i.idx_last) begin
            if (stat_i.code_ok) begin
              state_d       = S_CODE;
              cmd_o.idx_clr = 1'b1;
            end else begin
              state_d           = S_RUN;
              cmd_o.clear_frame = 1'b1;
            end
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      S_CODE: begin
        if (stat_i.out_free) begin
          cmd_o.load       = 1'b1;
          cmd_o.last_frame = stat_i.idx_last;
          if (stat_i.idx_last) begin
            state_d           = S_RUN;
            cmd_o.clear_frame = 1'b1;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      state_q <= S_RUN;
    end else begin
      phase_q <= phase_d;
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/skpr_datapath.sv
// Frame buffers, field splitter and output register.
module skpr_datapath #(
  parameter int unsigned BUFFER_BYTES = 64,
  parameter int unsigned TAG_BYTES    = 8,
  parameter int unsigned CODE_MAX     = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            action_i,
  input  logic [7:0]      rx_byte_i,
  input  skpr_pkg::cmd_t  cmd_i,
  output skpr_pkg::stat_t stat_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic            message_kind_o,
  output logic [7:0]      payload_byte_o,
  output logic            last_of_message_o,
  output logic            last_of_frame_o,
  output logic            overflowed_o
);
  import skpr_pkg::*;

  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES);
  localparam int unsigned MAXN  = (TAG_BYTES > CODE_MAX) ? TAG_BYTES : CODE_MAX;
  localparam int unsigned LW    = $clog2(MAXN + 2);
  localparam int unsigned TI_W  = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;
  localparam int unsigned CI_W  = (CODE_MAX > 1) ? $clog2(CODE_MAX) : 1;

  logic [CNT_W-1:0] count_q;
  logic [1:0]       field_q;
  logic [LW-1:0]    tag_len_q;
  logic [LW-1:0]    code_len_q;
  logic             text_end_q;
  logic             ovf_q;
  logic [LW-1:0]    idx_q;

  logic [7:0] tag_win_q  [TAG_BYTES];
  logic [7:0] code_buf_q [CODE_MAX];

  logic       out_valid_q;
  logic       kind_q;
  logic [7:0] byte_q;
  logic       last_msg_q;
  logic       last_frame_q;
  logic       out_ovf_q;

  logic       full;
  logic       idx_last;
  logic [7:0] rd_byte;

  assign full = (count_q >= CNT_W'(BUFFER_BYTES - 1));

  assign idx_last = cmd_i.sel_code ? ((idx_q + LW'(1)) == code_len_q)
                                   : (idx_q == LW'(TAG_BYTES - 1));
  assign rd_byte  = cmd_i.sel_code ? code_buf_q[idx_q[CI_W-1:0]]
                                   : tag_win_q[idx_q[TI_W-1:0]];

  always_comb begin
    stat_o.is_stx      = (rx_byte_i == CH_STX);
    stat_o.is_etx      = (rx_byte_i == CH_ETX);
    stat_o.is_timeout  = (action_i == ACT_TIMEOUT);
    stat_o.long_enough = (count_q > CNT_W'(MIN_DATA));
    stat_o.tag_ok      = (tag_len_q >= LW'(TAG_BYTES));
    stat_o.code_ok     = (code_len_q != '0) && (code_len_q <= LW'(CODE_MAX));
    stat_o.idx_last    = idx_last;
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  // Frame control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      field_q    <= '0;
      tag_len_q  <= '0;
      code_len_q <= '0;
      text_end_q <= 1'b0;
      ovf_q      <= 1'b0;
    end else if (cmd_i.clear_frame) begin
      count_q    <= '0;
      field_q    <= '0;
      tag_len_q  <= '0;
      code_len_q <= '0;
      text_end_q <= 1'b0;
      ovf_q      <= 1'b0;
    end else if (cmd_i.take_data) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        count_q <= count_q + CNT_W'(1);
        if (!text_end_q) begin
          if (rx_byte_i == CH_NUL) begin
            text_end_q <= 1'b1;
          end else if (rx_byte_i == CH_COLON) begin
            if (field_q != 2'd3) field_q <= field_q + 2'd1;
          end else if (field_q == 2'd0) begin
            if (tag_len_q < LW'(TAG_BYTES)) tag_len_q <= tag_len_q + LW'(1);
          end else if (field_q == 2'd1) begin
            if (code_len_q <= LW'(CODE_MAX)) code_len_q <= code_len_q + LW'(1);
          end
        end
      end
    end
  end

  // Tag window and code buffer, payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_data && !full && !text_end_q && (rx_byte_i != CH_NUL) &&
        (rx_byte_i != CH_COLON)) begin
      if (field_q == 2'd0) begin
        for (int i = 0; i < int'(TAG_BYTES) - 1; i++) begin
          tag_win_q[i] <= tag_win_q[i+1];
        end
        tag_win_q[TAG_BYTES-1] <= rx_byte_i;
      end else if ((field_q == 2'd1) && (code_len_q < LW'(CODE_MAX))) begin
        code_buf_q[code_len_q[CI_W-1:0]] <= rx_byte_i;
      end
    end
  end

  // Emit index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + LW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q       <= cmd_i.sel_code ? KIND_CODE : KIND_TAG;
      byte_q       <= rd_byte;
      last_msg_q   <= idx_last;
      last_frame_q <= cmd_i.last_frame;
      out_ovf_q    <= ovf_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign message_kind_o    = kind_q;
  assign payload_byte_o    = byte_q;
  assign last_of_message_o = last_msg_q;
  assign last_of_frame_o   = last_frame_q;
  assign overflowed_o      = out_ovf_q;

endmodule

FILE: bench/skpr_reply_monitor.sv
// Reply monitor: predicts keypad reply beats from input events and checks the output stream.
module skpr_reply_monitor #(
  parameter int unsigned BUFFER_BYTES = 64,
  parameter int unsigned TAG_BYTES    = 8,
  parameter int unsigned CODE_MAX     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] action
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // [7:0] payload_byte, [8] last_of_message, zero pad
  input  logic [1:0]  m_axis_tuser_i,   // [0] message_kind, [1] overflowed
  input  logic        m_axis_tlast_i,   // last_of_frame
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned beats_checked_o
);
  import skpr_pkg::*;

  typedef enum logic [1:0] {
    RX_WAIT_STX,
    RX_IN_FRAME,
    RX_SKIP_CHECK
  } rx_phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    logic       last_msg;
    logic       last_frame;
    logic       overflowed;
  } reply_beat_t;

  rx_phase_e   rx_phase;
  logic [1:0]  field_no;
  int unsigned stored_bytes;
  int unsigned tag_fill;
  int unsigned code_fill;
  logic [7:0]  tag_win [TAG_BYTES];
  logic [7:0]  code_buf [CODE_MAX];
  logic        text_done;
  logic        dropped_data;

  reply_beat_t reply_beats_due [$];
  int unsigned mismatch_count = 0;
  int unsigned beats_checked  = 0;

  assign mismatches_o    = mismatch_count;
  assign beats_checked_o = beats_checked;

  task automatic report_mismatch(input string msg);
    $display("mismatch at beat %0d: %s", beats_checked, msg);
    mismatch_count++;
  endtask

  task automatic clear_frame_state();
    field_no     = 2'd0;
    stored_bytes = 0;
    tag_fill     = 0;
    code_fill    = 0;
    text_done    = 1'b0;
    dropped_data = 1'b0;
  endtask

  task automatic store_data_byte(input logic [7:0] c);
    int unsigned i;
    if (stored_bytes >= BUFFER_BYTES - 1) begin
      dropped_data = 1'b1;
    end else begin
      stored_bytes++;
      // after a NUL the byte still counts toward length but joins no field
      if (!text_done) begin
        if (c == CH_NUL) begin
          text_done = 1'b1;
        end else if (c == CH_COLON) begin
          if (field_no != 2'd3) field_no++;
        end else if (field_no == 2'd0) begin
          for (i = 1; i < TAG_BYTES; i++) tag_win[i-1] = tag_win[i];
          tag_win[TAG_BYTES-1] = c;
          if (tag_fill < TAG_BYTES) tag_fill++;
        end else if (field_no == 2'd1) begin
          if (code_fill < CODE_MAX) code_buf[code_fill] = c;
          if (code_fill <= CODE_MAX) code_fill++;
        end
      end
    end
  endtask

  task automatic close_frame();
    reply_beat_t beat;
    int          total;
    int          n;
    int          i;
    logic        tag_ok;
    logic        code_ok;
    tag_ok  = (tag_fill >= TAG_BYTES);
    code_ok = (code_fill >= 1) && (code_fill <= CODE_MAX);
    total   = (tag_ok ? int'(TAG_BYTES) : 0) + (code_ok ? int'(code_fill) : 0);
    n       = 0;
    if (stored_bytes > MIN_DATA) begin
      if (tag_ok) begin
        for (i = 0; i < int'(TAG_BYTES); i++) begin
          beat.kind       = KIND_TAG;
          beat.payload    = tag_win[i];
          beat.last_msg   = (i == int'(TAG_BYTES) - 1);
          beat.last_frame = (n == total - 1);
          beat.overflowed = dropped_data;
          reply_beats_due.push_back(beat);
          n++;
        end
      end
      if (code_ok) begin
        for (i = 0; i < int'(code_fill); i++) begin
          beat.kind       = KIND_CODE;
          beat.payload    = code_buf[i];
          beat.last_msg   = (i == int'(code_fill) - 1);
          beat.last_frame = (n == total - 1);
          beat.overflowed = dropped_data;
          reply_beats_due.push_back(beat);
          n++;
        end
      end
    end
    clear_frame_state();
  endtask

  task automatic parse_event(input logic act, input logic [7:0] c);
    if (rx_phase == RX_SKIP_CHECK) begin
      rx_phase = RX_WAIT_STX;  // check byte or timeout, swallowed
    end else if (act == ACT_TIMEOUT) begin
      rx_phase = RX_WAIT_STX;
      close_frame();
    end else if (c == CH_STX) begin
      rx_phase = RX_IN_FRAME;
    end else if (c == CH_ETX) begin
      close_frame();
      rx_phase = RX_SKIP_CHECK;
    end else if (rx_phase == RX_IN_FRAME) begin
      store_data_byte(c);
    end
  endtask

  task automatic check_reply_beat();
    reply_beat_t want;
    if (reply_beats_due.size() == 0) begin
      report_mismatch($sformatf("unexpected beat, payload %02h", m_axis_tdata_i[7:0]));
    end else begin
      want = reply_beats_due.pop_front();
      if (m_axis_tuser_i[0] !== want.kind)
        report_mismatch($sformatf("message_kind %b, want %b", m_axis_tuser_i[0], want.kind));
      if (m_axis_tdata_i[7:0] !== want.payload)
        report_mismatch($sformatf("payload_byte %02h, want %02h", m_axis_tdata_i[7:0],
                                  want.payload));
      if (m_axis_tdata_i[8] !== want.last_msg)
        report_mismatch($sformatf("last_of_message %b, want %b", m_axis_tdata_i[8],
                                  want.last_msg));
      if (m_axis_tlast_i !== want.last_frame)
        report_mismatch($sformatf("last_of_frame %b, want %b", m_axis_tlast_i,
                                  want.last_frame));
      if (m_axis_tuser_i[1] !== want.overflowed)
        report_mismatch($sformatf("overflowed %b, want %b", m_axis_tuser_i[1],
                                  want.overflowed));
    end
    beats_checked++;
  endtask

  // Output side first: a beat leaving at this edge never belongs to an event taken at it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_phase = RX_WAIT_STX;
      clear_frame_state();
      reply_beats_due.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_reply_beat();
      if (s_axis_tvalid_i && s_axis_tready_i) parse_event(s_axis_tuser_i, s_axis_tdata_i);
      pending_o <= reply_beats_due.size();
    end
  end

endmodule

FILE: bench/testbench.sv
// Top of the keypad reply parser bench: clock, reset, serial event stimulus, verdict.
module testbench;
  import skpr_pkg::*;

  localparam int unsigned BUFFER_BYTES = 64;
  localparam int unsigned TAG_BYTES    = 8;
  localparam int unsigned CODE_MAX     = 8;

  // Burst of up to TAG_BYTES + CODE_MAX beats plus pipeline slack.
  localparam int SETTLE_CYCLES = TAG_BYTES + CODE_MAX + 8;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_EVENTS  = 50;

  // Frame shapes for the generator.
  localparam int SHAPE_ANY      = 0;
  localparam int SHAPE_FULL     = 1;  // full tag plus valid code, ETX ended
  localparam int SHAPE_OVERFLOW = 2;  // overruns the data buffer

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tuser  = ACT_BYTE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned beats_checked;

  int          idle_pct    = 0;   // sender gap odds, stimulus process only
  int          stall_pct   = 0;   // sink stall odds, written by NBA
  int          hold_req    = 0;
  int          hold_ack    = 0;
  int          hold_left   = 0;
  int unsigned cycle_count = 0;
  int unsigned events_sent = 0;
  int unsigned frames_sent = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  stx_etx_keypad_reply_parser #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .TAG_BYTES   (TAG_BYTES),
    .CODE_MAX    (CODE_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  skpr_reply_monitor #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .TAG_BYTES   (TAG_BYTES),
    .CODE_MAX    (CODE_MAX)
  ) u_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i (m_tdata),
    .m_axis_tuser_i (m_tuser),
    .m_axis_tlast_i (m_tlast),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .beats_checked_o(beats_checked)
  );

  // Watchdog: a hung handshake or missing beats end up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycle_count, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sink: random stalls, plus a long hold counted here whenever the
  // stimulus bumps hold_req. The hold lets the burst back up into the input.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Random frame text: any byte but NUL, STX, ETX or a colon.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CH_NUL || b == CH_STX || b == CH_ETX || b == CH_COLON);
    return b;
  endfunction

  // One serial event; random gaps before it, then hold until taken.
  task automatic send_event(input logic act, input logic [7:0] b, input bit counted);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= b;
    do @(posedge clk_i); while (!s_tready);
    if (counted) events_sent++;
  endtask

  task automatic send_timeout();
    send_event(ACT_TIMEOUT, 8'($urandom_range(255)), 1'b1);
  endtask

  // Sender pause: stop offering until every predicted beat is out.
  task automatic await_replies();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly well-formed frames: tag, colon, code, maybe a third field,
  // with occasional NULs, repeated STX, overruns and timeout endings.
  task automatic random_frame(input int shape);
    logic [7:0] body [$];
    int         tag_len;
    int         code_len;
    int         roll;
    bit         free_form;
    free_form = (shape == SHAPE_ANY);
    body = {};

    if (free_form && $urandom_range(99) < 30) send_event(ACT_BYTE, text_byte(), 1'b0);
    if (free_form && $urandom_range(99) < 8)
      send_event(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b1);

    // tag field
    if (!free_form || $urandom_range(99) < 70) tag_len = $urandom_range(TAG_BYTES + 4, TAG_BYTES);
    else tag_len = $urandom_range(TAG_BYTES - 1, 0);
    repeat (tag_len) body.push_back(text_byte());

    // code field, sometimes missing, empty or too long
    if (!free_form || $urandom_range(99) < 80) begin
      body.push_back(CH_COLON);
      roll = $urandom_range(99);
      if (!free_form || roll < 75) code_len = $urandom_range(CODE_MAX, 1);
      else if (roll < 85) code_len = 0;
      else code_len = $urandom_range(CODE_MAX + 3, CODE_MAX + 1);
      repeat (code_len) body.push_back(text_byte());
      if (free_form && $urandom_range(99) < 25) begin
        body.push_back(CH_COLON);
        repeat ($urandom_range(3)) body.push_back(($urandom_range(99) < 25) ? CH_COLON
                                                                            : text_byte());
      end
    end

    if (free_form && $urandom_range(99) < 10) body.insert($urandom_range(body.size()), CH_NUL);
    if (shape == SHAPE_OVERFLOW || (free_form && $urandom_range(99) < 3))
      repeat (BUFFER_BYTES) body.push_back(text_byte());

    send_event(ACT_BYTE, CH_STX, 1'b1);
    foreach (body[k]) begin
      if (free_form && $urandom_range(99) < 3) send_event(ACT_BYTE, CH_STX, 1'b1);
      send_event(ACT_BYTE, body[k], 1'b1);
    end

    // frame end: ETX plus any check byte, or a receive timeout
    if (!free_form || $urandom_range(99) < 75) begin
      send_event(ACT_BYTE, CH_ETX, 1'b1);
      if ($urandom_range(99) < 85) send_event(ACT_BYTE, 8'($urandom_range(255)), 1'b1);
      else send_timeout();
    end else begin
      send_timeout();
    end
    frames_sent++;
  endtask

  initial begin
    int phase_no;
    int goal;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: timeout and ETX before STX, STX as check byte,
    // extreme tag bytes with a one-byte code, timeout while awaiting
    // the check byte, and a short frame closed by timeout.
    send_timeout();
    send_event(ACT_BYTE, CH_ETX, 1'b1);
    send_event(ACT_BYTE, CH_STX, 1'b1);
    send_event(ACT_BYTE, CH_STX, 1'b1);
    send_event(ACT_BYTE, 8'hFF, 1'b1);
    send_event(ACT_BYTE, 8'h01, 1'b1);
    send_event(ACT_BYTE, 8'h80, 1'b1);
    send_event(ACT_BYTE, 8'h7F, 1'b1);
    send_event(ACT_BYTE, 8'h55, 1'b1);
    send_event(ACT_BYTE, 8'hAA, 1'b1);
    send_event(ACT_BYTE, 8'hFE, 1'b1);
    send_event(ACT_BYTE, 8'h04, 1'b1);
    send_event(ACT_BYTE, CH_COLON, 1'b1);
    send_event(ACT_BYTE, 8'h31, 1'b1);
    send_event(ACT_BYTE, CH_ETX, 1'b1);
    send_timeout();
    send_event(ACT_BYTE, CH_STX, 1'b1);
    send_event(ACT_BYTE, 8'h41, 1'b1);
    send_event(ACT_BYTE, 8'h42, 1'b1);
    send_event(ACT_BYTE, CH_COLON, 1'b1);
    send_event(ACT_BYTE, 8'h43, 1'b1);
    send_timeout();
    frames_sent += 4;
    await_replies();

    // Random part in four handshake mixes: clean, sender gaps,
    // sink stalls, both light.
    goal = events_sent;
    for (phase_no = 0; phase_no < 4; phase_no++) begin
      case (phase_no)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 60; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 60; end
        default: begin idle_pct = 11; stall_pct <= 11; end
      endcase
      goal += PHASE_EVENTS;

      if (phase_no == 0) begin
        // long sink hold while full frames keep coming: input backs up
        hold_req <= hold_req + 1;
        repeat (3) random_frame(SHAPE_FULL);
      end
      if (phase_no == 2) random_frame(SHAPE_OVERFLOW);

      while (events_sent < goal) random_frame(SHAPE_ANY);
      await_replies();
    end

    $display("covered %0d serial events in %0d frames over four gap/stall mixes",
             events_sent, frames_sent);
    $display("%0d reply beats compared, with a long sink hold and a buffer overrun",
             beats_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/skpr_pkg.sv
rtl/core/skpr_ctrl.sv
rtl/core/skpr_datapath.sv
rtl/core/stx_etx_keypad_reply_parser.sv
bench/skpr_reply_monitor.sv
bench/testbench.sv
